/* hw/rtl/lmrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix row scanner package
// Shared widths, reset values, register indexes and the scan stage record.
// ----------------------------------------------------------------------------
package lmrs_pkg;

   // Default geometry of the matrix.
   localparam int DEFAULT_COLUMN_BYTES = 320;
   localparam int DEFAULT_ROWS         = 7;

   // Field widths.
   localparam int ROW_W      = 3;
   localparam int BYTE_W     = 8;
   localparam int ADDRESS_W  = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 8;

   // Input item kinds.
   localparam logic ACTION_TICK  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE     = 8'd1;

   // Configuration reset values.
   localparam logic [BYTE_W-1:0] BRIGHTNESS_RESET = 8'd20;
   localparam logic              ENABLE_RESET     = 1'b1;

   // Row number of the first row.
   localparam logic [ROW_W-1:0] FIRST_ROW = 3'd1;

   // One scan step waiting for its frame buffer byte.
   typedef struct packed {
      logic             use_mem;   // data comes from the frame buffer byte
      logic [2:0]       bit_sel;   // bit of that byte, row minus one
      logic             data;      // data when it does not come from memory
      logic             pulse;
      logic             blank;
      logic [ROW_W-1:0] row;
   } scan_step_type;

endpackage

/* hw/rtl/lmrs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module lmrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 320,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the output holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/led_matrix_row_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix row scanner
// Scans a multiplexed LED matrix from a frame buffer held in RAM.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake        carries
//   req      in         valid / stall    action, address, write_value
//   rsp      out        valid / stall    serial_data, shift_pulse,
//                                        display_blank, row_number
//   csr      in         valid / ready    index, write_data
//
// One item is accepted per cycle while req_stall is low. A shifting tick reads its
// frame buffer byte at the accept edge and its result passes the RAM read register
// and then the output register. Write items produce no result.
// After reset a clearing pass zeroes the frame buffer, one byte per cycle;
// req_stall is high during it, csr writes go on.
// While the output register waits, one further tick is held in the read stage.
//
module led_matrix_row_scanner #(
   parameter int COLUMN_BYTES = lmrs_pkg::DEFAULT_COLUMN_BYTES,
   parameter int ROWS         = lmrs_pkg::DEFAULT_ROWS
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input items.
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic [lmrs_pkg::ADDRESS_W-1:0]     req_address,
   input  logic [lmrs_pkg::BYTE_W-1:0]        req_write_value,
   // Result items.
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_serial_data,
   output logic                               rsp_shift_pulse,
   output logic                               rsp_display_blank,
   output logic [lmrs_pkg::ROW_W-1:0]         rsp_row_number,
   // Configuration writes.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lmrs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lmrs_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   import lmrs_pkg::*;

   localparam int BitCount = COLUMN_BYTES + 3;
   localparam int PosW     = $clog2(BitCount);
   localparam int AddrW    = (COLUMN_BYTES > 1) ? $clog2(COLUMN_BYTES) : 1;

   // Configuration registers.
   logic [BYTE_W-1:0] brightness_ff, brightness_in;
   logic              enable_ff, enable_in;

   // Scan state.
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic              lit_ff, lit_in;
   logic [BYTE_W-1:0] dwell_ff, dwell_in;

   // Clearing pass.
   logic              clearing_ff, clearing_in;
   logic [AddrW-1:0]  clear_cnt_ff, clear_cnt_in;

   // Read stage and output register.
   logic          s1_valid_ff, s1_valid_in;
   scan_step_type s1_ff, s1_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_data_ff, out_data_in;
   logic          out_pulse_ff, out_pulse_in;
   logic          out_blank_ff, out_blank_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;

   // RAM ports.
   logic              ram_wr_en;
   logic [AddrW-1:0]  ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [BYTE_W-1:0] ram_rd_data;

   // Handshake terms.
   logic s1_adv;
   logic req_accept;
   logic tick_accept;
   logic write_accept;
   logic addr_in_range;
   logic [ROW_W-1:0] row_next;

   assign csr_ready = 1'b1;

   // The read stage moves on when the output register is free or drains.
   assign s1_adv       = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = clearing_ff || (s1_valid_ff && !s1_adv);
   assign req_accept   = req_valid && !req_stall;
   assign tick_accept  = req_accept && (req_action == ACTION_TICK);
   assign write_accept = req_accept && (req_action == ACTION_WRITE);
   assign addr_in_range = req_address < ADDRESS_W'(COLUMN_BYTES);

   // Row sequence from the first row up to ROWS, then back to the first row.
   assign row_next = (row_ff >= ROW_W'(ROWS)) ? FIRST_ROW : row_ff + 1'b1;

   // Frame buffer: the clearing pass owns the write port until it ends.
   always_comb begin
      if (clearing_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = write_accept && addr_in_range;
         ram_wr_addr = req_address[AddrW-1:0];
         ram_wr_data = req_write_value;
      end
   end

   assign ram_rd_en = tick_accept && enable_ff && !lit_ff &&
                      (pos_ff < PosW'(COLUMN_BYTES));

   lmrs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (COLUMN_BYTES)
   ) u_frame_buffer (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (pos_ff[AddrW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Clearing pass sequencing.
   always_comb begin
      clearing_in  = clearing_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clearing_ff) begin
         if (clear_cnt_ff == AddrW'(COLUMN_BYTES - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clear_cnt_in = clear_cnt_ff + 1'b1;
         end
      end
   end

   // Configuration writes.
   always_comb begin
      brightness_in = brightness_ff;
      enable_in     = enable_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BRIGHTNESS: brightness_in = csr_write_data;
            CSR_ENABLE:     enable_in     = csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Scan step: next state and the record of this tick's result.
   always_comb begin
      row_in   = row_ff;
      pos_in   = pos_ff;
      lit_in   = lit_ff;
      dwell_in = dwell_ff;

      s1_in.use_mem = 1'b0;
      s1_in.bit_sel = 3'(row_ff - 1'b1);
      s1_in.data    = 1'b0;
      s1_in.pulse   = 1'b0;
      s1_in.blank   = 1'b1;
      s1_in.row     = row_ff;

      if (tick_accept) begin
         if (!enable_ff) begin
            // Disabled: stay blanked and step the row.
            pos_in   = '0;
            lit_in   = 1'b0;
            dwell_in = '0;
            row_in   = row_next;
         end else if (!lit_ff) begin
            // Shifting: column bits, then the row number's three bits.
            s1_in.pulse = 1'b1;
            if (pos_ff < PosW'(COLUMN_BYTES)) begin
               s1_in.use_mem = 1'b1;
            end else if (pos_ff == PosW'(COLUMN_BYTES)) begin
               s1_in.data = row_ff[2];
            end else if (pos_ff == PosW'(COLUMN_BYTES + 1)) begin
               s1_in.data = row_ff[1];
            end else begin
               s1_in.data = row_ff[0];
            end
            if (pos_ff == PosW'(BitCount - 1)) begin
               pos_in   = '0;
               lit_in   = 1'b1;
               dwell_in = (brightness_ff == '0) ? BYTE_W'(1) : brightness_ff;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end else begin
            // Lit: count down the dwell, then move to the next row.
            s1_in.blank = 1'b0;
            if (dwell_ff <= BYTE_W'(1)) begin
               dwell_in = '0;
               lit_in   = 1'b0;
               row_in   = row_next;
            end else begin
               dwell_in = dwell_ff - 1'b1;
            end
         end
      end
   end

   // Read stage and output register flow.
   always_comb begin
      s1_valid_in  = tick_accept || (s1_valid_ff && !s1_adv);
      out_valid_in = s1_adv || (out_valid_ff && rsp_stall);
      out_data_in  = out_data_ff;
      out_pulse_in = out_pulse_ff;
      out_blank_in = out_blank_ff;
      out_row_in   = out_row_ff;
      if (s1_adv) begin
         out_data_in  = s1_ff.use_mem ? !ram_rd_data[s1_ff.bit_sel] : s1_ff.data;
         out_pulse_in = s1_ff.pulse;
         out_blank_in = s1_ff.blank;
         out_row_in   = s1_ff.row;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHTNESS_RESET;
         enable_ff     <= ENABLE_RESET;
         row_ff        <= FIRST_ROW;
         pos_ff        <= '0;
         lit_ff        <= 1'b0;
         dwell_ff      <= '0;
         clearing_ff   <= 1'b1;
         clear_cnt_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         brightness_ff <= brightness_in;
         enable_ff     <= enable_in;
         row_ff        <= row_in;
         pos_ff        <= pos_in;
         lit_ff        <= lit_in;
         dwell_ff      <= dwell_in;
         clearing_ff   <= clearing_in;
         clear_cnt_ff  <= clear_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (tick_accept) begin
         s1_ff <= s1_in;
      end
      out_data_ff  <= out_data_in;
      out_pulse_ff <= out_pulse_in;
      out_blank_ff <= out_blank_in;
      out_row_ff   <= out_row_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_serial_data   = out_data_ff;
   assign rsp_shift_pulse   = out_pulse_ff;
   assign rsp_display_blank = out_blank_ff;
   assign rsp_row_number    = out_row_ff;

endmodule
